@@ src/b64d_pkg.sv @@
// b64d_pkg: shared types, the alphabet lookup and the byte packing helpers
// for the base64 stream decoder; depends on nothing
`timescale 1ns / 1ps

package b64d_pkg;

  typedef logic [5:0] sextet_t;

  typedef struct packed {
    logic    ok;
    sextet_t val;
  } lookup_t;

  // one unit of work for the back end: one to three results
  typedef struct packed {
    logic [2:0][7:0] data;
    logic [1:0]      cnt;
    logic            has_bytes;
    logic            msg_end;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  localparam logic [7:0] PadChar = 8'h3d;

  function automatic lookup_t sextet_of(input logic [7:0] c);
    lookup_t r;
    r.ok  = 1'b1;
    r.val = '0;
    if (c >= 8'h41 && c <= 8'h5a) begin
      r.val = sextet_t'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      r.val = sextet_t'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r.val = sextet_t'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2b) begin
      r.val = 6'd62;
    end else if (c == 8'h2f) begin
      r.val = 6'd63;
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [7:0] pack0(input sextet_t a, input sextet_t b);
    return {a, b[5:4]};
  endfunction

  function automatic logic [7:0] pack1(input sextet_t b, input sextet_t d);
    return {b[3:0], d[5:2]};
  endfunction

  function automatic logic [7:0] pack2(input sextet_t d, input sextet_t e);
    return {d[1:0], e};
  endfunction

endpackage

@@ src/b64d_front.sv @@
// b64d_front: takes characters, keeps the group state and builds jobs
// depends on b64d_pkg
`timescale 1ns / 1ps

module b64d_front
  import b64d_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  input  logic [7:0] in_char,
  input  logic       in_last_char,
  input  q_stat_t    q_stat,
  output logic       job_push,
  output job_t       job
);

  logic [1:0]         group_count_r, group_count_nxt;
  sextet_t [2:0]      held_r, held_nxt;
  logic               stopped_r, stopped_nxt;

  lookup_t            lk;
  logic               accept;
  logic               take;
  logic               full_group;
  sextet_t [2:0]      held_w;
  logic [1:0]         gc_w;

  assign accept = in_push && !q_stat.full;
  assign lk     = sextet_of(in_char);
  assign take   = !stopped_r && lk.ok;
  assign full_group = take && (group_count_r == 2'd3);

  always_comb begin
    held_w = held_r;
    gc_w   = group_count_r;
    if (take && !full_group) begin
      held_w[group_count_r] = lk.val;
      gc_w = group_count_r + 2'd1;
    end else if (full_group) begin
      gc_w = 2'd0;
    end
  end

  always_comb begin
    job.data      = '0;
    job.cnt       = 2'd0;
    job.has_bytes = 1'b1;
    job.msg_end   = in_last_char;
    if (full_group) begin
      job.data[0] = pack0(held_r[0], held_r[1]);
      job.data[1] = pack1(held_r[1], held_r[2]);
      job.data[2] = pack2(held_r[2], lk.val);
      job.cnt     = 2'd3;
    end else if (in_last_char) begin
      job.data[0] = pack0(held_w[0], held_w[1]);
      job.data[1] = pack1(held_w[1], held_w[2]);
      if (gc_w == 2'd3) begin
        job.cnt = 2'd2;
      end else begin
        job.cnt = 2'd1;
        // flush with fewer than two values: bare end marker
        if (gc_w != 2'd2) begin
          job.data      = '0;
          job.has_bytes = 1'b0;
        end
      end
    end
  end

  assign job_push = accept && (job.cnt != 2'd0);

  always_comb begin
    group_count_nxt = group_count_r;
    held_nxt        = held_r;
    stopped_nxt     = stopped_r;
    if (accept) begin
      if (in_last_char) begin
        group_count_nxt = 2'd0;
        held_nxt        = '0;
        stopped_nxt     = 1'b0;
      end else begin
        group_count_nxt = gc_w;
        held_nxt        = held_w;
        // pad or foreign character stops the message
        if (!stopped_r && !lk.ok) begin
          stopped_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_count_r <= 2'd0;
      held_r        <= '0;
      stopped_r     <= 1'b0;
    end else begin
      group_count_r <= group_count_nxt;
      held_r        <= held_nxt;
      stopped_r     <= stopped_nxt;
    end
  end

endmodule

@@ src/b64d_fifo.sv @@
// b64d_fifo: short job queue between the front and the back end
// depends on b64d_pkg
`timescale 1ns / 1ps

module b64d_fifo
  import b64d_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    wr_en,
  input  job_t    wr_data,
  input  logic    rd_en,
  output job_t    rd_data,
  output q_stat_t stat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t           mem_r [DEPTH];
  logic [AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           do_wr, do_rd;

  assign stat.full  = (count_r == CW'(DEPTH));
  assign stat.empty = (count_r == '0);
  assign do_wr      = wr_en && !stat.full;
  assign do_rd      = rd_en && !stat.empty;
  assign rd_data    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + CW'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

@@ src/b64d_back.sv @@
// b64d_back: unpacks jobs into single result transfers from an output register
// depends on b64d_pkg
`timescale 1ns / 1ps

module b64d_back
  import b64d_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  q_stat_t    q_stat,
  input  job_t       q_data,
  output logic       q_pop,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_message_end
);

  job_t       job_r, job_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       busy_r, busy_nxt;
  logic       last_of_job;
  logic       xfer;

  assign last_of_job = (idx_r == job_r.cnt - 2'd1);
  assign xfer        = out_pop && busy_r;
  assign q_pop       = (!busy_r || (xfer && last_of_job)) && !q_stat.empty;

  assign out_empty       = !busy_r;
  assign out_byte        = job_r.data[idx_r];
  assign out_byte_valid  = job_r.has_bytes;
  assign out_message_end = job_r.msg_end && last_of_job;

  always_comb begin
    job_nxt  = job_r;
    idx_nxt  = idx_r;
    busy_nxt = busy_r;
    if (q_pop) begin
      job_nxt  = q_data;
      idx_nxt  = 2'd0;
      busy_nxt = 1'b1;
    end else if (xfer && last_of_job) begin
      busy_nxt = 1'b0;
    end else if (xfer) begin
      idx_nxt = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= 2'd0;
      busy_r <= 1'b0;
    end else begin
      idx_r  <= idx_nxt;
      busy_r <= busy_nxt;
    end
  end

endmodule

@@ src/base64_stream_decoder_unit.sv @@
// base64_stream_decoder_unit: top level, front end, job queue and back end
// depends on b64d_pkg, b64d_front, b64d_fifo, b64d_back
//
//   channel  | handshake            | payload
//   ---------+----------------------+------------------------------------------
//   input    | in_push / in_full    | in_char, in_last_char
//   result   | out_pop / out_empty  | out_byte, out_byte_valid, out_message_end
//
// one character is taken every cycle while the job queue has room
// the back end hands out one result per cycle while out_pop is high
// a result shows once its job has passed the queue into the back end register
// synchronous reset empties the queue and clears the group state
// a stalled result side fills the queue of JOB_DEPTH jobs, then in_full rises
`timescale 1ns / 1ps

module base64_stream_decoder_unit
  import b64d_pkg::*;
#(
  parameter int JOB_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_char,
  input  logic       in_last_char,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_message_end
);

  q_stat_t q_stat;
  job_t    job_in, job_out;
  logic    job_push, job_pop;

  assign in_full = q_stat.full;

  b64d_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_char      (in_char),
    .in_last_char (in_last_char),
    .q_stat       (q_stat),
    .job_push     (job_push),
    .job          (job_in)
  );

  b64d_fifo #(
    .DEPTH (JOB_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (job_push),
    .wr_data (job_in),
    .rd_en   (job_pop),
    .rd_data (job_out),
    .stat    (q_stat)
  );

  b64d_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_stat          (q_stat),
    .q_data          (job_out),
    .q_pop           (job_pop),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_byte        (out_byte),
    .out_byte_valid  (out_byte_valid),
    .out_message_end (out_message_end)
  );

endmodule

@@ src/b64d_checker.sv @@
// b64d_checker: port-level checks on the decoder, bound to the top level
// depends on base64_stream_decoder_unit
`timescale 1ns / 1ps

module b64d_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_full,
  input logic       out_empty,
  input logic       out_pop,
  input logic [7:0] out_byte,
  input logic       out_byte_valid,
  input logic       out_message_end
);

  a_reset_empty : assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result side not empty after reset");

  a_reset_not_full : assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("input side full after reset");

  a_marker_ends : assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_byte_valid) |-> out_message_end)
    else $error("empty marker without message end");

  a_stall_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=>
      (!out_empty && $stable(out_byte) && $stable(out_byte_valid)
       && $stable(out_message_end)))
    else $error("stalled result changed");

endmodule

bind base64_stream_decoder_unit b64d_checker u_b64d_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_full         (in_full),
  .out_empty       (out_empty),
  .out_pop         (out_pop),
  .out_byte        (out_byte),
  .out_byte_valid  (out_byte_valid),
  .out_message_end (out_message_end)
);

@@ sim/tb_base64_stream_decoder_unit.sv @@
// tb_base64_stream_decoder_unit: self-checking testbench for the base64 stream decoder,
// with its own decode predictor, random idling on both queue sides and a long receiver hold
// depends on b64d_pkg and base64_stream_decoder_unit
`timescale 1ns / 1ps

module tb_base64_stream_decoder_unit;
  import b64d_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       msg_end;
  } dec_byte_t;

  logic       clk;
  logic       rst_n;
  logic       in_push;
  logic       in_full;
  logic [7:0] in_char;
  logic       in_last_char;
  logic       out_empty;
  logic       out_pop;
  logic [7:0] out_byte;
  logic       out_byte_valid;
  logic       out_message_end;

  dec_byte_t  pending_bytes[$];
  logic [1:0] grp_held;
  sextet_t    held_val[3];
  logic       stopped;

  logic idle_en;
  logic hold_req;
  logic hold_rx;
  int   err_count;
  int   n_items;
  int   n_msgs;
  int   n_checked;

  base64_stream_decoder_unit u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_char        (in_char),
    .in_last_char   (in_last_char),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_message_end(out_message_end)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("status: fail");
    $finish;
  end

  // {ok, value} for one character of the standard alphabet
  function automatic logic [6:0] char_sextet(input logic [7:0] c);
    logic [7:0] t;
    t = 8'h00;
    if (c >= "A" && c <= "Z") begin
      t = c - "A";
    end else if (c >= "a" && c <= "z") begin
      t = c - "a" + 8'd26;
    end else if (c >= "0" && c <= "9") begin
      t = c - "0" + 8'd52;
    end else if (c == "+") begin
      t = 8'd62;
    end else if (c == "/") begin
      t = 8'd63;
    end else begin
      return 7'h00;
    end
    return {1'b1, t[5:0]};
  endfunction

  function automatic logic [7:0] alpha_char(input int v);
    if (v < 26) return 8'(int'("A") + v);
    if (v < 52) return 8'(int'("a") + v - 26);
    if (v < 62) return 8'(int'("0") + v - 52);
    if (v == 62) return "+";
    return "/";
  endfunction

  function automatic logic [7:0] first_byte(input sextet_t a, input sextet_t b);
    return (8'(a) << 2) | (8'(b) >> 4);
  endfunction

  function automatic logic [7:0] second_byte(input sextet_t b, input sextet_t d);
    return (8'(b & 6'h0f) << 4) | (8'(d) >> 2);
  endfunction

  function automatic logic [7:0] third_byte(input sextet_t d, input sextet_t e);
    return (8'(d & 6'h03) << 6) | 8'(e);
  endfunction

  task automatic clear_decoder_state();
    grp_held = 2'd0;
    held_val[0] = '0;
    held_val[1] = '0;
    held_val[2] = '0;
    stopped = 1'b0;
  endtask

  task automatic predict_char(input logic [7:0] c, input logic is_last);
    dec_byte_t  outs[3];
    logic [6:0] m;
    int         n;
    n = 0;
    m = char_sextet(c);
    if (!stopped) begin
      if (!m[6]) begin
        stopped = 1'b1;
      end else if (grp_held == 2'd3) begin
        outs[0] = {first_byte(held_val[0], held_val[1]), 1'b1, 1'b0};
        outs[1] = {second_byte(held_val[1], held_val[2]), 1'b1, 1'b0};
        outs[2] = {third_byte(held_val[2], m[5:0]), 1'b1, 1'b0};
        n = 3;
        grp_held = 2'd0;
      end else begin
        held_val[grp_held] = m[5:0];
        grp_held = grp_held + 2'd1;
      end
    end
    if (is_last) begin
      if (grp_held >= 2'd2) begin
        outs[n] = {first_byte(held_val[0], held_val[1]), 1'b1, 1'b0};
        n++;
      end
      if (grp_held == 2'd3) begin
        outs[n] = {second_byte(held_val[1], held_val[2]), 1'b1, 1'b0};
        n++;
      end
      if (n == 0) begin
        outs[0] = {8'h00, 1'b0, 1'b1};
        n = 1;
      end else begin
        outs[n-1].msg_end = 1'b1;
      end
      clear_decoder_state();
      n_msgs++;
    end
    for (int i = 0; i < n; i++) pending_bytes.push_back(outs[i]);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  task automatic check_result();
    dec_byte_t w;
    if (pending_bytes.size() == 0) begin
      report_mismatch("unexpected result", int'(out_byte), 0);
    end else begin
      w = pending_bytes.pop_front();
      n_checked++;
      if (out_byte_valid !== w.valid) begin
        report_mismatch("byte_valid", int'(out_byte_valid), int'(w.valid));
      end
      if (out_byte !== w.data) begin
        report_mismatch("out_byte", int'(out_byte), int'(w.data));
      end
      if (out_message_end !== w.msg_end) begin
        report_mismatch("message_end", int'(out_message_end), int'(w.msg_end));
      end
    end
  endtask

  // result side: random stalls plus the long hold
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    out_pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_rx) begin
        out_pop = 1'b0;
      end else if (stall_left > 0) begin
        out_pop = 1'b0;
        stall_left--;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        out_pop = 1'b0;
        stall_left = $urandom_range(0, 2);
      end else begin
        out_pop = 1'b1;
      end
      @(posedge clk);
      if (rst_n && out_pop && !out_empty) check_result();
    end
  end

  initial begin : hold_counter
    hold_rx = 1'b0;
    forever begin
      wait (hold_req);
      @(posedge clk);
      hold_rx = 1'b1;
      repeat (60) @(posedge clk);
      hold_rx = 1'b0;
      wait (!hold_req);
    end
  end

  task automatic send_char(input logic [7:0] c, input logic is_last);
    int gap;
    if (idle_en && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 3);
      repeat (gap) begin
        @(negedge clk);
        in_push = 1'b0;
        in_char = 8'($urandom_range(0, 255));
        in_last_char = 1'($urandom_range(0, 1));
      end
    end
    @(negedge clk);
    in_push = 1'b1;
    in_char = c;
    in_last_char = is_last;
    @(posedge clk);
    while (in_full) @(posedge clk);
    predict_char(c, is_last);
    n_items++;
  endtask

  task automatic send_text(input string s, input logic end_msg);
    for (int i = 0; i < s.len(); i++) send_char(s[i], end_msg && (i == s.len() - 1));
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_push = 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic test_full_groups();
    send_text("TWFu", 1'b1);
    send_text("+/9z", 1'b0);
    send_text("AZa0", 1'b0);
    send_char("*", 1'b1);
    drain_results();
  endtask

  task automatic test_pad_and_flush();
    send_text("TWE=", 1'b1);
    send_text("TQ=X", 1'b1);
    send_text("Q", 1'b1);
    send_char(8'h00, 1'b1);
    send_char("/", 1'b0);
    send_char(8'hff, 1'b1);
    drain_results();
  endtask

  task automatic test_backpressure();
    idle_en = 1'b0;
    hold_req = 1'b1;
    send_text("QUJDREVGR0hJSktMTU5PUFFSU1RVVldY", 1'b1);
    drain_results();
    hold_req = 1'b0;
    idle_en = 1'b1;
  endtask

  task automatic send_random_message();
    logic [7:0] msg[$];
    logic [7:0] bad;
    logic [6:0] bad_map;
    int         kind;
    int         body_len;
    int         tail;
    int         bad_pos;
    kind = $urandom_range(0, 9);
    if (kind == 9) begin
      repeat ($urandom_range(1, 6)) msg.push_back(8'($urandom_range(0, 255)));
    end else begin
      tail = $urandom_range(0, 3);
      body_len = 4 * $urandom_range(0, 3) + tail;
      bad_pos = (kind >= 7) ? int'($urandom_range(0, body_len)) : -1;
      if ($urandom_range(0, 3) == 0) begin
        bad = PadChar;
      end else begin
        bad = 8'($urandom_range(0, 255));
        bad_map = char_sextet(bad);
        while (bad_map[6]) begin
          bad = 8'($urandom_range(0, 255));
          bad_map = char_sextet(bad);
        end
      end
      for (int i = 0; i <= body_len; i++) begin
        if (i == bad_pos) msg.push_back(bad);
        if (i < body_len) msg.push_back(alpha_char($urandom_range(0, 63)));
      end
      if (tail >= 2 && $urandom_range(0, 1) == 1) begin
        repeat (4 - tail) msg.push_back(PadChar);
      end
      if (kind >= 7) begin
        repeat ($urandom_range(0, 3)) msg.push_back(alpha_char($urandom_range(0, 63)));
      end
      if (msg.size() == 0) msg.push_back(alpha_char($urandom_range(0, 63)));
    end
    for (int i = 0; i < msg.size(); i++) send_char(msg[i], i == msg.size() - 1);
  endtask

  task automatic test_random_messages(input int item_count);
    int stop_at;
    stop_at = n_items + item_count;
    while (n_items < stop_at) send_random_message();
    drain_results();
  endtask

  task automatic test_steady_stream(input int item_count);
    idle_en = 1'b0;
    test_random_messages(item_count);
  endtask

  initial begin
    rst_n = 1'b0;
    in_push = 1'b0;
    in_char = 8'h00;
    in_last_char = 1'b0;
    idle_en = 1'b1;
    hold_req = 1'b0;
    err_count = 0;
    n_items = 0;
    n_msgs = 0;
    n_checked = 0;
    clear_decoder_state();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_full_groups();
    test_pad_and_flush();
    test_backpressure();
    test_random_messages(65);
    test_steady_stream(25);

    if (pending_bytes.size() != 0) report_mismatch("results never seen", pending_bytes.size(), 0);
    $display("run covered %0d characters in %0d messages, %0d results checked",
             n_items, n_msgs, n_checked);
    $display("groups, pads, foreign bytes, partial flushes, stalls and a full queue exercised");
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
